/* rtl/mfh_pkg.sv */
// ============================================================================
// mfh_pkg
// Types, codes and helpers shared by the frame header field parser modules.
// ============================================================================
package mfh_pkg;

    // default packet length cap (bytes) and queue depth
    localparam int MAX_PACKET_BYTES_DEF = 512;
    localparam int QUEUE_DEPTH_DEF      = 4;

    // byte position counter, wide enough for a packet cap up to 8191
    localparam int COUNT_W = 13;

    // configuration register indexes
    localparam logic CFG_IFRAME_MODE   = 1'b0;
    localparam logic CFG_EXPECTED_TYPE = 1'b1;

    localparam logic [7:0] EXPECTED_TYPE_RST = 8'h02;

    // frame control codes
    localparam logic [2:0] FT_ACK       = 3'd2;
    localparam logic [1:0] ADDR_MODE_16 = 2'd2;
    localparam logic [1:0] ADDR_MODE_64 = 2'd3;
    localparam logic [3:0] META_BYTES   = 4'd5;
    localparam logic [3:0] FCF_BYTES    = 4'd2;
    localparam logic [4:0] KIND_META_END = 5'd16;

    // parser phase; members carry the field kind code they emit, but PH_META bytes emit 11 to 15
    typedef enum logic [4:0] {
        PH_TYPE    = 5'd0,
        PH_LEN     = 5'd1,
        PH_FCF     = 5'd2,
        PH_SEQ     = 5'd3,
        PH_DPAN    = 5'd4,
        PH_DADDR   = 5'd5,
        PH_SPAN    = 5'd6,
        PH_SADDR   = 5'd7,
        PH_IFRAME  = 5'd8,
        PH_AM      = 5'd9,
        PH_PAYLOAD = 5'd10,
        PH_META    = 5'd11,
        PH_TS      = 5'd16
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } in_word_t;

    typedef struct packed {
        logic [4:0]  field_kind;
        logic [63:0] field_value;
        logic [2:0]  frame_type;
        logic        security_on;
        logic        frame_pending;
        logic        ack_request;
        logic        intra_pan;
        logic        type_error;
        logic        length_mismatch;
        logic        short_error;
        logic        truncated;
        logic        last;
    } out_word_t;

    // word moved from the front end to the parser through the queue
    typedef struct packed {
        logic [7:0]         data_byte;
        logic               eop;
        logic [COUNT_W-1:0] count;
    } q_word_t;

    function automatic logic [3:0] addr_len(input logic [1:0] mode);
        logic [3:0] n;
        n = 4'd0;
        if (mode == ADDR_MODE_16) n = 4'd2;
        if (mode == ADDR_MODE_64) n = 4'd8;
        return n;
    endfunction

    // byte length of an addressing-stage field
    function automatic logic [3:0] field_len(input logic [4:0] p, input logic [15:0] fcf,
                                             input logic ifm);
        logic [3:0] n;
        case (p)
            PH_DPAN:   n = (fcf[11:10] == ADDR_MODE_16 || fcf[11:10] == ADDR_MODE_64)
                           ? 4'd2 : 4'd0;
            PH_DADDR:  n = addr_len(fcf[11:10]);
            PH_SPAN:   n = fcf[6] ? 4'd0 : 4'd2;
            PH_SADDR:  n = addr_len(fcf[15:14]);
            PH_IFRAME: n = {3'd0, ifm};
            default:   n = 4'd1;
        endcase
        return n;
    endfunction

    // first phase at or after start that has bytes, stopping at the am type
    function automatic logic [4:0] enter_phase(input logic [4:0] start, input logic [15:0] fcf,
                                               input logic ifm);
        logic [4:0] p;
        p = start;
        for (int i = 0; i < 5; i++) begin
            if (p < PH_AM && field_len(p, fcf, ifm) == 4'd0) p = p + 5'd1;
        end
        return p;
    endfunction

endpackage

/* rtl/mfh_queue.sv */
// ============================================================================
// mfh_queue
// Small register queue between the front end and the field parser.
// ============================================================================
module mfh_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/mfh_front.sv */
// ============================================================================
// mfh_front
// Input side: takes bytes and tags each with its position in the packet.
// ============================================================================
module mfh_front #(
    parameter int MAX_PACKET_BYTES = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mfh_pkg::in_word_t in_data,
    input  logic              q_full,
    output logic              q_push,
    output mfh_pkg::q_word_t  q_data
);
    import mfh_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] pos;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // position saturates at the packet cap
    assign pos = (count_reg < COUNT_W'(MAX_PACKET_BYTES)) ? count_reg + COUNT_W'(1)
                                                           : count_reg;

    assign q_data.data_byte = in_data.data_byte;
    assign q_data.eop       = in_data.end_of_packet;
    assign q_data.count     = pos;

    always_comb
    begin
        count_next = count_reg;
        if (q_push)
        begin
            count_next = in_data.end_of_packet ? '0 : pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/mfh_back.sv */
// ============================================================================
// mfh_back
// Field parser: walks the header phases one word per cycle into a result reg; stalls on out_ready.
// ============================================================================
module mfh_back #(
    parameter int MAX_PACKET_BYTES = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               q_valid,
    input  mfh_pkg::q_word_t   q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output mfh_pkg::out_word_t out_data
);
    import mfh_pkg::*;

    logic        iframe_mode_reg;
    logic [7:0]  exp_type_reg;

    phase_t      phase_reg, phase_next;
    logic [3:0]  left_reg, left_next;
    logic [63:0] acc_reg, acc_next;
    logic [15:0] fcf_reg, fcf_next;
    logic [7:0]  dlen_reg, dlen_next;
    logic        te_reg, te_next;
    logic        ss_reg, ss_next;

    logic               out_valid_reg;
    out_word_t          out_data_reg;

    logic [7:0]         b;
    logic [COUNT_W-1:0] c;
    logic [COUNT_W-1:0] dlen_ext;
    logic [3:0]         left_dec;
    logic [3:0]         meta_left;
    logic [4:0]         ent;
    logic               done;
    logic [4:0]         kind;
    logic [63:0]        value;
    out_word_t          res;

    assign b         = q_data.data_byte;
    assign c         = q_data.count;
    assign dlen_ext  = COUNT_W'(dlen_reg);
    assign left_dec  = (left_reg != 4'd0) ? left_reg - 4'd1 : 4'd0;
    assign meta_left = (left_reg == 4'd0 || left_reg > META_BYTES) ? META_BYTES : left_reg;

    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // entry point of the next addressing stage
    always_comb
    begin
        case (phase_reg)
            PH_SEQ:    ent = enter_phase(PH_DPAN, fcf_reg, iframe_mode_reg);
            PH_IFRAME: ent = enter_phase(PH_AM, fcf_reg, iframe_mode_reg);
            default:   ent = enter_phase(phase_reg + 5'd1, fcf_reg, iframe_mode_reg);
        endcase
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        acc_next   = acc_reg;
        fcf_next   = fcf_reg;
        dlen_next  = dlen_reg;
        te_next    = te_reg;
        ss_next    = ss_reg;
        case (phase_reg)
            PH_TYPE:
            begin
                te_next    = (b != exp_type_reg);
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                dlen_next  = b;
                phase_next = PH_FCF;
                left_next  = FCF_BYTES;
                acc_next   = '0;
            end
            PH_FCF:
            begin
                acc_next  = (left_reg >= FCF_BYTES) ? {56'd0, b} : (acc_reg | {48'd0, b, 8'd0});
                left_next = left_dec;
                if (left_dec == 4'd0)
                begin
                    fcf_next   = acc_next[15:0];
                    phase_next = PH_SEQ;
                end
            end
            PH_SEQ:
            begin
                if (fcf_reg[2:0] == FT_ACK)
                begin
                    phase_next = PH_META;
                    left_next  = META_BYTES;
                end
                else
                begin
                    phase_next = phase_t'(ent);
                    left_next  = field_len(ent, fcf_reg, iframe_mode_reg);
                    acc_next   = '0;
                end
            end
            PH_DPAN, PH_DADDR, PH_SPAN, PH_SADDR:
            begin
                acc_next  = {acc_reg[55:0], b};
                left_next = left_dec;
                if (left_dec == 4'd0)
                begin
                    phase_next = phase_t'(ent);
                    left_next  = field_len(ent, fcf_reg, iframe_mode_reg);
                    acc_next   = '0;
                end
            end
            PH_IFRAME:
            begin
                phase_next = phase_t'(ent);
                left_next  = field_len(ent, fcf_reg, iframe_mode_reg);
                acc_next   = '0;
            end
            PH_AM:
            begin
                if (c >= dlen_ext)
                begin
                    ss_next    = 1'b1;
                    phase_next = PH_META;
                    left_next  = META_BYTES;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (c >= dlen_ext + COUNT_W'(2) || c == COUNT_W'(MAX_PACKET_BYTES))
                begin
                    phase_next = PH_META;
                    left_next  = META_BYTES;
                end
            end
            PH_META:
            begin
                left_next = meta_left - 4'd1;
                if (meta_left == 4'd1)
                begin
                    phase_next = PH_TS;
                end
            end
            default:
            begin
                phase_next = PH_TS;
            end
        endcase
    end

    // result of the current word
    always_comb
    begin
        done  = 1'b1;
        kind  = phase_reg;
        value = {56'd0, b};
        case (phase_reg)
            PH_FCF:
            begin
                done  = (left_dec == 4'd0);
                value = acc_next;
            end
            PH_DPAN, PH_DADDR, PH_SPAN, PH_SADDR:
            begin
                done  = (left_dec == 4'd0);
                value = {acc_reg[55:0], b};
            end
            PH_META:
            begin
                kind = KIND_META_END - {1'b0, meta_left};
            end
            default:
            begin
                kind = phase_reg;
            end
        endcase
        res.field_kind      = kind;
        res.field_value     = value;
        res.frame_type      = fcf_next[2:0];
        res.security_on     = fcf_next[3];
        res.frame_pending   = fcf_next[4];
        res.ack_request     = fcf_next[5];
        res.intra_pan       = fcf_next[6];
        res.type_error      = te_next;
        res.length_mismatch = q_data.eop && (COUNT_W'(dlen_next) != c);
        res.short_error     = ss_next;
        res.truncated       = q_data.eop && !done;
        res.last            = q_data.eop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iframe_mode_reg <= 1'b0;
            exp_type_reg    <= EXPECTED_TYPE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IFRAME_MODE:   iframe_mode_reg <= cfg_data[0];
                CFG_EXPECTED_TYPE: exp_type_reg    <= cfg_data;
                default:           iframe_mode_reg <= iframe_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            left_reg  <= '0;
            acc_reg   <= '0;
            fcf_reg   <= '0;
            dlen_reg  <= '0;
            te_reg    <= 1'b0;
            ss_reg    <= 1'b0;
        end
        else if (q_pop)
        begin
            if (q_data.eop)
            begin
                phase_reg <= PH_TYPE;
                left_reg  <= '0;
                acc_reg   <= '0;
                fcf_reg   <= '0;
                dlen_reg  <= '0;
                te_reg    <= 1'b0;
                ss_reg    <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                left_reg  <= left_next;
                acc_reg   <= acc_next;
                fcf_reg   <= fcf_next;
                dlen_reg  <= dlen_next;
                te_reg    <= te_next;
                ss_reg    <= ss_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop && (done || q_data.eop))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && (done || q_data.eop))
        begin
            out_data_reg <= res;
        end
    end

endmodule

/* rtl/mac_frame_header_field_parser.sv */
// ============================================================================
// mac_frame_header_field_parser
// Byte-serial parser for the header fields of a wrapped radio frame.
// ============================================================================
//  channel   direction  handshake              word
//  in        input      in_valid / in_ready    in_data (byte, end of packet)
//  out       output     out_valid / out_ready  out_data (one parsed field)
//  cfg       input      cfg_we                 cfg_index, cfg_data
//
//  one byte per cycle sustained while out_ready does not stall; a byte that is
//  taken is written to the queue, then to the result register by the parser stage
//  the parser handles one queued byte per cycle and stalls only on out_ready
//  in_ready drops only when the queue (QUEUE_DEPTH words) is full
//  reset clears the queue and the packet state and resets the config registers
// ============================================================================
module mac_frame_header_field_parser #(
    parameter int MAX_PACKET_BYTES = mfh_pkg::MAX_PACKET_BYTES_DEF,
    parameter int QUEUE_DEPTH      = mfh_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  mfh_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output mfh_pkg::out_word_t out_data
);
    import mfh_pkg::*;

    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_valid;
    q_word_t q_in;
    q_word_t q_out;

    mfh_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data (in_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    mfh_queue #(
        .WIDTH($bits(q_word_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_in),
        .full     (q_full),
        .pop      (q_pop),
        .pop_data (q_out),
        .not_empty(q_valid)
    );

    mfh_back #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .q_valid  (q_valid),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

endmodule

/* rtl/mfh_checker.sv */
// ============================================================================
// mfh_checker
// Port-level checks on the frame header field parser results.
// ============================================================================
module mfh_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input mfh_pkg::out_word_t out_data
);
    import mfh_pkg::*;

    // a waiting result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // length check is reported only on the closing field
    a_mismatch_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.length_mismatch |-> out_data.last)
        else $error("length mismatch on a non-final field");

    // a cut-off field always closes the packet
    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.truncated |-> out_data.last)
        else $error("truncated field not final");

    // the type byte comes before any frame control or short flags
    a_type_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.field_kind == 5'(PH_TYPE) |->
            out_data.frame_type == 3'd0 && !out_data.short_error && !out_data.truncated)
        else $error("type field carries stale packet flags");

endmodule

bind mac_frame_header_field_parser mfh_checker u_mfh_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
);
